/* rtl/core/vhist_pkg.sv */
// ----------------------------------------------------------------------------
// vhist_pkg
// Shared types and codes for the variable-edge histogram.
// ----------------------------------------------------------------------------
`default_nettype none

package vhist_pkg;

    // number of edge registers and field widths
    localparam int EDGE_REGS  = 7;
    localparam int BIN_W      = 3;
    localparam int VALUE_W    = 32;
    localparam int CFG_IDX_W  = 3;

    // depth of the internal queues
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;

    typedef logic signed [VALUE_W-1:0] t_edge;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_EDGE_COUNT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_EDGE_A     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_EDGE_G     = 3'd7;

    // input op codes
    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_REPORT = 1'b1;

    // result kinds
    localparam logic KIND_BIN   = 1'b0;
    localparam logic KIND_RANGE = 1'b1;

    // classified command handed from front to back
    typedef enum logic [1:0] {
        CMD_COUNT,
        CMD_REJECT,
        CMD_REPORT
    } t_cmd_op;

    typedef struct packed {
        t_cmd_op          op;
        logic [BIN_W-1:0] bin;
        t_edge            sample;
    } t_cmd;

    // one result item
    typedef struct packed {
        logic               kind;
        logic [BIN_W-1:0]   bin_index;
        logic [VALUE_W-1:0] hit_count;
        t_edge              low_edge;
        t_edge              high_edge;
        logic               last;
    } t_result;

    // back end sequencer
    typedef enum logic {
        BK_IDLE,
        BK_REPORT
    } t_back_state;

endpackage

`default_nettype wire

/* rtl/core/vhist_fifo.sv */
// ----------------------------------------------------------------------------
// vhist_fifo
// Small register queue with full and empty flags.
// ----------------------------------------------------------------------------
`default_nettype none

module vhist_fifo #(
    parameter int P_WIDTH = 8
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_push,
    input  wire logic [P_WIDTH-1:0] i_data,
    output logic                    o_full,
    input  wire logic               i_pop,
    output logic [P_WIDTH-1:0]      o_data,
    output logic                    o_empty
);
    import vhist_pkg::*;

    logic [P_WIDTH-1:0] r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  r_wr_ptr;
    logic [QPTR_W-1:0]  r_rd_ptr;
    logic [QPTR_W:0]    r_count;
    logic               wr_en;
    logic               rd_en;

    // flags
    assign o_full  = (r_count == (QPTR_W+1)'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign wr_en   = i_push && !o_full;
    assign rd_en   = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd_ptr];

    // storage
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (wr_en) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (rd_en) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (wr_en && !rd_en) begin
                r_count <= r_count + 1'b1;
            end else if (rd_en && !wr_en) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

/* rtl/core/vhist_front.sv */
// ----------------------------------------------------------------------------
// vhist_front
// Classifies an incoming item against all edges at once.
// ----------------------------------------------------------------------------
`default_nettype none

module vhist_front #(
    parameter int MAX_BINS = 6
) (
    input  wire logic                   i_op,
    input  wire vhist_pkg::t_edge       i_sample_value,
    input  wire logic [2:0]             i_edge_count,
    input  wire vhist_pkg::t_edge       i_edges [vhist_pkg::EDGE_REGS],
    output vhist_pkg::t_cmd             o_cmd
);
    import vhist_pkg::*;

    localparam logic [BIN_W-1:0] EDGE_LIM = BIN_W'(MAX_BINS + 1);

    logic [BIN_W-1:0] n_eff;
    t_edge            top;
    logic             done;
    logic             hit;
    logic [BIN_W-1:0] bin;

    // number of edges in use
    assign n_eff = (i_edge_count > EDGE_LIM) ? EDGE_LIM : i_edge_count;
    assign top   = i_edges[n_eff - 3'd1];

    // scan from bin 0 upward; first step that settles the sample wins
    always_comb begin
        done = 1'b0;
        hit  = 1'b0;
        bin  = '0;
        if (n_eff >= 3'd2) begin
            for (int i = 0; i < MAX_BINS; i++) begin
                if (!done && (BIN_W'(i + 1) < n_eff)) begin
                    if ((i_sample_value < i_edges[i]) || (i_sample_value > top)) begin
                        done = 1'b1;
                    end else if (i_sample_value < i_edges[i+1]) begin
                        done = 1'b1;
                        hit  = 1'b1;
                        bin  = BIN_W'(i);
                    end else if (i_sample_value == top) begin
                        done = 1'b1;
                        hit  = 1'b1;
                        bin  = n_eff - 3'd2;
                    end
                end
            end
        end
    end

    // command to the back end
    always_comb begin
        o_cmd.sample = i_sample_value;
        o_cmd.bin    = bin;
        if (i_op == OP_REPORT) begin
            o_cmd.op = CMD_REPORT;
        end else if (hit) begin
            o_cmd.op = CMD_COUNT;
        end else begin
            o_cmd.op = CMD_REJECT;
        end
    end

endmodule

`default_nettype wire

/* rtl/core/vhist_back.sv */
// ----------------------------------------------------------------------------
// vhist_back
// Holds the bin counters, applies commands and walks the bins for reports.
// ----------------------------------------------------------------------------
`default_nettype none

module vhist_back #(
    parameter int MAX_BINS    = 6,
    parameter int COUNT_WIDTH = 32
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire vhist_pkg::t_cmd     i_cmd,
    input  wire logic                i_cmd_empty,
    output logic                     o_cmd_pop,
    input  wire vhist_pkg::t_edge    i_edges [vhist_pkg::EDGE_REGS],
    output vhist_pkg::t_result       o_res,
    output logic                     o_res_push,
    input  wire logic                i_res_full
);
    import vhist_pkg::*;

    localparam int IDX_W = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_BINS - 1);

    t_back_state            r_state;
    t_back_state            n_state;
    logic [IDX_W-1:0]       r_idx;
    logic [IDX_W-1:0]       n_idx;
    logic [COUNT_WIDTH-1:0] r_count [MAX_BINS];

    logic [MAX_BINS-1:0]    nz;
    logic                   more_above;
    logic                   step;
    logic                   count_inc;
    logic [IDX_W-1:0]       cmd_bin;
    logic [63:0]            count_wide;
    logic [BIN_W-1:0]       edge_lo;

    // nonzero bins and whether any lies above the current one
    always_comb begin
        more_above = 1'b0;
        for (int j = 0; j < MAX_BINS; j++) begin
            nz[j] = (r_count[j] != '0);
            if (nz[j] && (IDX_W'(j) > r_idx)) begin
                more_above = 1'b1;
            end
        end
    end

    assign step       = !nz[r_idx] || !i_res_full;
    assign cmd_bin    = i_cmd.bin[IDX_W-1:0];
    assign count_wide = 64'(r_count[r_idx]);
    assign edge_lo    = BIN_W'(r_idx);

    // next state
    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        unique case (r_state)
            BK_IDLE: begin
                if (!i_cmd_empty && (i_cmd.op == CMD_REPORT)) begin
                    n_state = BK_REPORT;
                    n_idx   = '0;
                end
            end
            BK_REPORT: begin
                if (step) begin
                    if (r_idx == LAST_IDX) begin
                        n_state = BK_IDLE;
                    end else begin
                        n_idx = r_idx + 1'b1;
                    end
                end
            end
            default: begin
                n_state = BK_IDLE;
            end
        endcase
    end

    // outputs
    always_comb begin
        o_cmd_pop  = 1'b0;
        o_res_push = 1'b0;
        count_inc  = 1'b0;
        o_res      = '0;
        unique case (r_state)
            BK_IDLE: begin
                if (!i_cmd_empty) begin
                    unique case (i_cmd.op)
                        CMD_COUNT: begin
                            o_cmd_pop = 1'b1;
                            count_inc = 1'b1;
                        end
                        CMD_REJECT: begin
                            o_cmd_pop      = !i_res_full;
                            o_res_push     = !i_res_full;
                            o_res.kind     = KIND_RANGE;
                            o_res.low_edge = i_cmd.sample;
                            o_res.last     = 1'b1;
                        end
                        CMD_REPORT: begin
                            o_cmd_pop = 1'b1;
                        end
                        default: begin
                            o_cmd_pop = 1'b1;
                        end
                    endcase
                end
            end
            BK_REPORT: begin
                o_res_push      = nz[r_idx] && !i_res_full;
                o_res.kind      = KIND_BIN;
                o_res.bin_index = edge_lo;
                o_res.hit_count = (count_wide[63:32] != '0) ? '1 : count_wide[31:0];
                o_res.low_edge  = i_edges[edge_lo];
                o_res.high_edge = i_edges[edge_lo + 3'd1];
                o_res.last      = !more_above;
            end
            default: begin
            end
        endcase
    end

    // sequencer registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BK_IDLE;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
        end
    end

    // saturating bin counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < MAX_BINS; k++) begin
                r_count[k] <= '0;
            end
        end else if (count_inc && (r_count[cmd_bin] != '1)) begin
            r_count[cmd_bin] <= r_count[cmd_bin] + 1'b1;
        end
    end

endmodule

`default_nettype wire

/* rtl/core/variable_edge_histogram.sv */
// ----------------------------------------------------------------------------
// variable_edge_histogram
// Histogram of signed samples over programmable, ascending bin edges.
// ----------------------------------------------------------------------------
// Samples: one per cycle while the command queue is not full; a counted sample
//   updates its bin counter from the head of the command queue, and an out-of-range
//   result reaches the result ports through the command and result queues.
// Reports: the command is taken in the idle state, then one bin per cycle;
//   stalls on a bin only while the result queue is full.
// Reset clears edge count, edges, bin counters and both queues.
// ----------------------------------------------------------------------------
`default_nettype none

module variable_edge_histogram #(
    parameter int MAX_BINS    = 6,
    parameter int COUNT_WIDTH = 32
) (
    input  wire logic                                    i_clk,
    input  wire logic                                    i_rst_n,
    // item input
    input  wire logic                                    push,
    output logic                                         full,
    input  wire logic                                    i_op,
    input  wire logic signed [vhist_pkg::VALUE_W-1:0]    i_sample_value,
    // result output
    output logic                                         empty,
    input  wire logic                                    pop,
    output logic                                         o_kind,
    output logic [vhist_pkg::BIN_W-1:0]                  o_bin_index,
    output logic [vhist_pkg::VALUE_W-1:0]                o_hit_count,
    output logic signed [vhist_pkg::VALUE_W-1:0]         o_low_edge,
    output logic signed [vhist_pkg::VALUE_W-1:0]         o_high_edge,
    output logic                                         o_last,
    // configuration write
    input  wire logic                                    i_cfg_valid,
    output logic                                         o_cfg_ready,
    input  wire logic [vhist_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  wire logic [vhist_pkg::VALUE_W-1:0]           i_cfg_data
);
    import vhist_pkg::*;

    logic [2:0] r_edge_count;
    t_edge      r_edges [EDGE_REGS];

    t_cmd       front_cmd;
    t_cmd       back_cmd;
    logic       cmd_empty;
    logic       cmd_pop;
    t_result    back_res;
    t_result    out_res;
    logic       res_push;
    logic       res_full;

    // configuration registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_edge_count <= '0;
            for (int k = 0; k < EDGE_REGS; k++) begin
                r_edges[k] <= '0;
            end
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index) inside
                CFG_EDGE_COUNT: begin
                    r_edge_count <= i_cfg_data[2:0];
                end
                [CFG_EDGE_A:CFG_EDGE_G]: begin
                    r_edges[i_cfg_index - 3'd1] <= i_cfg_data;
                end
                default: begin
                end
            endcase
        end
    end

    // classify incoming items
    vhist_front #(
        .MAX_BINS (MAX_BINS)
    ) u_front (
        .i_op           (i_op),
        .i_sample_value (i_sample_value),
        .i_edge_count   (r_edge_count),
        .i_edges        (r_edges),
        .o_cmd          (front_cmd)
    );

    // command queue between front and back
    vhist_fifo #(
        .P_WIDTH ($bits(t_cmd))
    ) u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (front_cmd),
        .o_full  (full),
        .i_pop   (cmd_pop),
        .o_data  (back_cmd),
        .o_empty (cmd_empty)
    );

    // counters and report sequencer
    vhist_back #(
        .MAX_BINS    (MAX_BINS),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (back_cmd),
        .i_cmd_empty (cmd_empty),
        .o_cmd_pop   (cmd_pop),
        .i_edges     (r_edges),
        .o_res       (back_res),
        .o_res_push  (res_push),
        .i_res_full  (res_full)
    );

    // result queue
    vhist_fifo #(
        .P_WIDTH ($bits(t_result))
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (back_res),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_data  (out_res),
        .o_empty (empty)
    );

    // result fields
    assign o_kind      = out_res.kind;
    assign o_bin_index = out_res.bin_index;
    assign o_hit_count = out_res.hit_count;
    assign o_low_edge  = out_res.low_edge;
    assign o_high_edge = out_res.high_edge;
    assign o_last      = out_res.last;

endmodule

`default_nettype wire

/* verif/variable_edge_histogram_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// variable_edge_histogram_tb
// Self-checking bench for the programmable-edge histogram. A bursty driver
// feeds sample and report commands and a stalling monitor pops results. A
// local copy of the edges and bin tallies predicts every result. The edges
// are reprogrammed between phases while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module variable_edge_histogram_tb;

    import vhist_pkg::*;

    localparam int NUM_BINS     = 6;
    localparam int SETTLE       = 24;
    localparam int HOLD_CYCLES  = 300;
    localparam int RAND_PHASES  = 8;
    localparam int PHASE_ITEMS  = 45;
    localparam int PRESS_PHASE  = 2;
    localparam int VALUE_MIN    = 32'sh8000_0000;
    localparam int VALUE_MAX    = 32'sh7fff_ffff;

    // one command to the histogram
    typedef struct packed {
        logic               op;
        logic signed [31:0] value;
    } t_hist_cmd;

    logic                                i_clk          = 1'b0;
    logic                                i_rst_n        = 1'b0;
    logic                                push           = 1'b0;
    logic                                full;
    logic                                i_op           = OP_SAMPLE;
    logic signed [VALUE_W-1:0]           i_sample_value = '0;
    logic                                empty;
    logic                                pop            = 1'b0;
    logic                                o_kind;
    logic [BIN_W-1:0]                    o_bin_index;
    logic [VALUE_W-1:0]                  o_hit_count;
    logic signed [VALUE_W-1:0]           o_low_edge;
    logic signed [VALUE_W-1:0]           o_high_edge;
    logic                                o_last;
    logic                                i_cfg_valid    = 1'b0;
    logic                                o_cfg_ready;
    logic [CFG_IDX_W-1:0]                i_cfg_index    = CFG_EDGE_COUNT;
    logic [VALUE_W-1:0]                  i_cfg_data     = '0;

    // predictor state: programmed edges and bin tallies
    int          edge_tab  [EDGE_REGS];
    logic [2:0]  cfg_nedges;
    bit   [31:0] bin_tally [NUM_BINS];

    t_hist_cmd cmd_backlog [$];
    t_result   due_entries [$];
    int        plan_edges  [EDGE_REGS];
    int        fail_count  = 0;

    // sender burst state
    int burst_left = 0;
    int gap_left   = 0;

    // receiver long hold-off
    logic hold_req   = 1'b0;
    logic hold_taken = 1'b0;
    int   hold_left  = 0;
    int   rx_cycle   = 0;

    variable_edge_histogram #(
        .MAX_BINS    (NUM_BINS),
        .COUNT_WIDTH (32)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .push           (push),
        .full           (full),
        .i_op           (i_op),
        .i_sample_value (i_sample_value),
        .empty          (empty),
        .pop            (pop),
        .o_kind         (o_kind),
        .o_bin_index    (o_bin_index),
        .o_hit_count    (o_hit_count),
        .o_low_edge     (o_low_edge),
        .o_high_edge    (o_high_edge),
        .o_last         (o_last),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    // clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // bin lookup: scan edges upward, reject below current edge or above top
    function automatic int find_bin(input int s);
        int n;
        int top;
        n = cfg_nedges;
        if (n > NUM_BINS + 1) n = NUM_BINS + 1;
        if (n < 2) return -1;
        top = edge_tab[n-1];
        for (int i = 0; i < n - 1; i++) begin
            if (s < edge_tab[i] || s > top) return -1;
            if (s < edge_tab[i+1]) return i;
            if (s == top) return n - 2;
        end
        return -1;
    endfunction

    // append one expected result at the tail
    task automatic queue_result(input t_result r);
        due_entries.insert(due_entries.size(), r);
    endtask

    // append one pending command at the tail
    task automatic queue_cmd(input t_hist_cmd c);
        cmd_backlog.insert(cmd_backlog.size(), c);
    endtask

    // apply one accepted command to the tallies and queue its results
    task automatic histogram_step(input t_hist_cmd c);
        t_result r;
        t_result prev;
        logic    have_prev;
        int      b;
        have_prev = 1'b0;
        if (c.op == OP_SAMPLE) begin
            b = find_bin(c.value);
            if (b < 0) begin
                r.kind      = KIND_RANGE;
                r.bin_index = '0;
                r.hit_count = '0;
                r.low_edge  = c.value;
                r.high_edge = '0;
                r.last      = 1'b1;
                queue_result(r);
            end else if (bin_tally[b] != 32'hffff_ffff) begin
                bin_tally[b] = bin_tally[b] + 1;
            end
        end else begin
            for (int i = 0; i < NUM_BINS; i++) begin
                if (bin_tally[i] != 0) begin
                    if (have_prev) queue_result(prev);
                    prev.kind      = KIND_BIN;
                    prev.bin_index = i[BIN_W-1:0];
                    prev.hit_count = bin_tally[i];
                    prev.low_edge  = edge_tab[i];
                    prev.high_edge = edge_tab[i+1];
                    prev.last      = 1'b0;
                    have_prev      = 1'b1;
                end
            end
            if (have_prev) begin
                prev.last = 1'b1;
                queue_result(prev);
            end
        end
    endtask

    task automatic check_field(input string what, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, what, want, got);
            fail_count++;
        end
    endtask

    // driver: bursts of commands with random gaps, holds while full
    always @(posedge i_clk) begin : drv
        t_hist_cmd next_cmd;
        if (!i_rst_n) begin
            push       <= 1'b0;
            burst_left = 1;
            gap_left   = 0;
        end else begin
            if (push && !full) histogram_step(cmd_backlog.pop_front());
            if (!(push && full)) begin
                if (gap_left > 0) begin
                    gap_left--;
                    push <= 1'b0;
                end else if (cmd_backlog.size() != 0) begin
                    next_cmd        = cmd_backlog[0];
                    push           <= 1'b1;
                    i_op           <= next_cmd.op;
                    i_sample_value <= next_cmd.value;
                    if (burst_left > 1) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(1, 24);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end else begin
                    push <= 1'b0;
                end
            end
        end
    end

    // long receiver hold-off, started once on request
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left  <= 0;
            hold_taken <= 1'b0;
        end else if (hold_req && !hold_taken) begin
            hold_left  <= HOLD_CYCLES;
            hold_taken <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // monitor: check each result transfer, pop on a rotating stall pattern
    always @(posedge i_clk) begin : mon
        t_result want_r;
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop && !empty) begin
                if (due_entries.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual kind %0d low_edge %h",
                             $time, o_kind, o_low_edge);
                    fail_count++;
                end else begin
                    want_r = due_entries.pop_front();
                    check_field("kind", want_r.kind, o_kind);
                    check_field("bin_index", want_r.bin_index, o_bin_index);
                    check_field("hit_count", want_r.hit_count, o_hit_count);
                    check_field("low_edge", want_r.low_edge, o_low_edge);
                    check_field("high_edge", want_r.high_edge, o_high_edge);
                    check_field("last", want_r.last, o_last);
                end
            end
            rx_cycle++;
            if (hold_left > 0 || (hold_req && !hold_taken)) begin
                pop <= 1'b0;
            end else begin
                case ((rx_cycle >> 7) % 4)
                    0: pop <= 1'b1;
                    1: pop <= 1'($urandom_range(0, 1));
                    2: pop <= ($urandom_range(0, 3) == 0);
                    default: pop <= ((rx_cycle % 3) != 0);
                endcase
            end
        end
    end

    // one register write transfer; caller drops valid after the last one
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        if (idx == CFG_EDGE_COUNT) cfg_nedges = data[2:0];
        else edge_tab[idx - CFG_EDGE_A] = data;
    endtask

    // write the edge count and all planned edges, starting at a random index
    task automatic apply_plan(input int nedges);
        int                   rot;
        logic [CFG_IDX_W-1:0] idx;
        rot = $urandom_range(0, 7);
        for (int k = 0; k < 8; k++) begin
            idx = CFG_IDX_W'((k + rot) % 8);
            if (idx == CFG_EDGE_COUNT)
                write_reg(idx, ($urandom() & ~32'h7) | nedges[2:0]);
            else
                write_reg(idx, plan_edges[idx - CFG_EDGE_A]);
        end
        i_cfg_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (cmd_backlog.size() != 0 || push || due_entries.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic add_sample(input int v);
        t_hist_cmd c;
        c.op    = OP_SAMPLE;
        c.value = v;
        queue_cmd(c);
    endtask

    task automatic add_report();
        t_hist_cmd c;
        c.op    = OP_REPORT;
        c.value = $urandom();
        queue_cmd(c);
    endtask

    // random edge sets: sorted wide, dense steps, unsorted, or full-scale
    task automatic plan_random_edges(input int mode);
        int t;
        for (int i = 0; i < EDGE_REGS; i++) begin
            case (mode)
                1: plan_edges[i] = (i == 0) ? $urandom() : plan_edges[i-1] + $urandom_range(0, 40);
                2: plan_edges[i] = $urandom_range(0, 200) - 100;
                default: plan_edges[i] = $urandom();
            endcase
        end
        if (mode == 0 || mode == 3) begin
            for (int i = 1; i < EDGE_REGS; i++) begin
                for (int j = i; j > 0 && plan_edges[j-1] > plan_edges[j]; j--) begin
                    t               = plan_edges[j];
                    plan_edges[j]   = plan_edges[j-1];
                    plan_edges[j-1] = t;
                end
            end
        end
        if (mode == 3) begin
            plan_edges[0] = VALUE_MIN;
            plan_edges[6] = VALUE_MAX;
        end
    endtask

    // mostly samples close to a programmed edge, some anywhere
    function automatic int pick_sample();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return edge_tab[$urandom_range(0, 6)] + $urandom_range(0, 6) - 3;
        if (r < 80) return edge_tab[$urandom_range(0, 6)] + $urandom_range(0, 2000) - 1000;
        return $urandom();
    endfunction

    initial begin
        int nedges;
        int mode;
        edge_tab   = '{default: 0};
        bin_tally  = '{default: 0};
        cfg_nedges = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset state: no edges, every sample rejected, empty report
        add_sample(VALUE_MIN);
        add_sample(VALUE_MAX);
        add_report();
        wait_drained();

        // one edge only: still too few to form a bin
        plan_edges = '{VALUE_MIN, -1000, -1, 0, 1, 1000, VALUE_MAX};
        apply_plan(1);
        add_sample(0);
        wait_drained();

        // full span of all edge registers, boundaries and the top edge
        apply_plan(7);
        add_sample(VALUE_MIN);
        add_sample(-1001);
        add_sample(-1000);
        add_sample(-2);
        add_sample(-1);
        add_sample(0);
        add_sample(1);
        add_sample(999);
        add_sample(1000);
        add_sample(VALUE_MAX);
        add_report();
        wait_drained();

        // fewer edges; old counts reported with the new edges
        plan_edges[0] = 10;
        plan_edges[1] = 20;
        plan_edges[2] = 30;
        apply_plan(3);
        add_sample(9);
        add_sample(10);
        add_sample(29);
        add_sample(30);
        add_sample(31);
        add_report();
        wait_drained();

        // edges out of order
        plan_edges[1] = 100;
        plan_edges[2] = 50;
        plan_edges[3] = 200;
        plan_edges[0] = 0;
        apply_plan(4);
        add_sample(75);
        add_sample(150);
        add_report();
        wait_drained();

        // random phases, one of them with the receiver held off
        for (int p = 0; p < RAND_PHASES; p++) begin
            mode   = (p == 0) ? 3 : (p == PRESS_PHASE) ? 1 : $urandom_range(0, 3);
            nedges = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 7) : 7;
            if (p == PRESS_PHASE) nedges = 7;
            plan_random_edges(mode);
            apply_plan(nedges);
            if (p == PRESS_PHASE) hold_req <= 1'b1;
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                if ($urandom_range(0, 9) < ((p == PRESS_PHASE) ? 3 : 1))
                    add_report();
                else if (p == PRESS_PHASE && $urandom_range(0, 1) == 0)
                    add_sample($urandom());
                else
                    add_sample(pick_sample());
            end
            wait_drained();
        end

        if (fail_count == 0 && due_entries.size() == 0)
            $display("** variable_edge_histogram: PASSED **");
        else
            $display("** variable_edge_histogram: FAILED **");
        $finish;
    end

    // watchdog
    initial begin
        #2_000_000;
        $display("** variable_edge_histogram: FAILED **");
        $finish;
    end

endmodule

`default_nettype wire
